### hw/rtl/bzs_pkg.sv
// Shared types, constants and helper functions of the cubic Bezier sampler.
package bzs_pkg;

    // Parameter value that stands for one, and the largest curvature code.
    localparam logic [16:0] ONE_T    = 17'd65536;
    localparam logic [23:0] CURV_MAX = 24'hFFFFFF;
    localparam logic [15:0] SIGN16   = 16'h8000;

    // Configuration register indexes.
    localparam logic [1:0] REG_P0 = 2'd0;
    localparam logic [1:0] REG_P1 = 2'd1;
    localparam logic [1:0] REG_P2 = 2'd2;
    localparam logic [1:0] REG_P3 = 2'd3;

    // Number of stages in the back end's tail pipeline.
    localparam int NT = 61;

    // One queued item: the clamped parameter and its complement.
    typedef struct packed {
        logic [16:0] t;
        logic [16:0] u;
    } t_item;

    // The four control points, x y z packed.
    typedef logic [3:0][47:0] t_points;

    // State of one square root iteration: remainder and partial root.
    typedef struct packed {
        logic [57:0] x;
        logic [57:0] r;
    } t_sqs;

    // Everything one item carries through the tail pipeline.
    typedef struct packed {
        logic [47:0]       pos;
        logic [47:0]       vel;
        logic [47:0]       acc;
        logic [2:0][20:0]  vi;
        logic [2:0][22:0]  ai;
        logic [2:0][40:0]  sq;
        logic [5:0][43:0]  xp;
        logic [2:0][19:0]  vmag;
        logic [2:0]        vneg;
        logic [41:0]       v2;
        logic [2:0][29:0]  c;
        logic [2:0][57:0]  cs;
        t_sqs              vsq;
        t_sqs              csq;
        logic [20:0]       s;
        logic [15:0]       speed;
        logic [2:0][37:0]  tr;
        logic [2:0][15:0]  tq;
        logic [41:0]       ss;
        logic [61:0]       den;
        logic [29:0]       cn;
        logic [62:0]       crem;
        logic [24:0]       cquo;
        logic              covf;
        logic [47:0]       tan;
        logic [23:0]       curv;
        logic              regular;
    } t_tail;

    // One step of the digit-by-digit square root.
    function automatic t_sqs sqrt_step(input t_sqs st, input logic [57:0] b);
        logic [58:0] sum;
        t_sqs        res;
        sum = {1'b0, st.r} + {1'b0, b};
        if ({1'b0, st.x} >= sum) begin
            res.x = st.x - sum[57:0];
            res.r = (st.r >> 1) + b;
        end else begin
            res.x = st.x;
            res.r = st.r >> 1;
        end
        return res;
    endfunction

    // Clamp a signed value to the 16-bit two's complement range.
    function automatic logic [15:0] sat16(input logic signed [23:0] v);
        logic [15:0] res;
        if (v > 24'sd32767) begin
            res = 16'h7FFF;
        end else if (v < -24'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/bzs_front.sv
// Front end: takes parameter items, clamps them to one and forms the complement.
module bzs_front
    import bzs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [16:0] i_fraction,
    input  logic        i_full,
    output logic        o_push,
    output t_item       o_item
);

    logic        r_valid;
    logic        n_valid;
    t_item       r_item;
    t_item       n_item;
    logic        accept;

    // The holding register is blocked only while the queue is full.
    assign busy   = r_valid & i_full;
    assign accept = start & ~busy;
    assign o_push = r_valid & ~i_full;
    assign o_item = r_item;

    // Saturate t above one and compute u = 1 - t.
    always_comb begin
        n_valid = accept | (r_valid & i_full);
        n_item  = r_item;
        if (accept) begin
            n_item.t = (i_fraction > ONE_T) ? ONE_T : i_fraction;
            n_item.u = ONE_T - n_item.t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

### hw/rtl/bzs_queue.sv
// Two-entry queue between the front end and the evaluation pipeline.
module bzs_queue
    import bzs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    t_item       r_mem [2];
    logic        r_rd;
    logic        r_wr;
    logic [1:0]  r_cnt;
    logic        pop;

    // The pipeline behind never stalls, so the head leaves whenever present.
    assign pop     = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = pop;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

### hw/rtl/bzs_back.sv
// Back end: pipelined curve evaluation, square roots and divisions.
module bzs_back
    import bzs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    input  t_points     i_points,
    output logic        o_valid,
    output logic [47:0] o_position,
    output logic [47:0] o_velocity,
    output logic [47:0] o_acceleration,
    output logic [15:0] o_speed,
    output logic        o_regular,
    output logic [47:0] o_unit_tangent,
    output logic [23:0] o_curvature
);

    // Control point fields, offset forms and differences per axis.
    logic        [15:0] pu [3][4];
    logic signed [16:0] d0 [3];
    logic signed [16:0] d1 [3];
    logic signed [16:0] d2 [3];
    logic signed [17:0] e0 [3];
    logic signed [17:0] e1 [3];

    always_comb begin
        logic signed [17:0] p [4];
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 4; k++) begin
                pu[a][k] = i_points[k][16 * a +: 16] ^ SIGN16;
                p[k]     = 18'($signed(i_points[k][16 * a +: 16]));
            end
            d0[a] = 17'(p[1] - p[0]);
            d1[a] = 17'(p[2] - p[1]);
            d2[a] = 17'(p[3] - p[2]);
            e0[a] = p[2] - (p[1] <<< 1) + p[0];
            e1[a] = p[3] - (p[2] <<< 1) + p[1];
        end
    end

    // Stage 1: parameter and complement.
    logic        r1_v;
    logic [16:0] r1_t;
    logic [16:0] r1_u;

    // Stage 2: second powers.
    logic        r2_v;
    logic [16:0] r2_t;
    logic [16:0] r2_u;
    logic [32:0] r2_uu;
    logic [32:0] r2_ut;
    logic [32:0] r2_tt;

    // Stage 3: Bernstein weights and derivative partial products.
    logic               r3_v;
    logic        [48:0] r3_w   [4];
    logic signed [49:0] r3_pv0 [3];
    logic signed [49:0] r3_pv1 [3];
    logic signed [49:0] r3_pv2 [3];
    logic signed [35:0] r3_pa0 [3];
    logic signed [35:0] r3_pa1 [3];

    // Stage 4: weighted control points and derivative sums.
    logic               r4_v;
    logic        [63:0] r4_pp [3][4];
    logic signed [51:0] r4_sv [3];
    logic signed [37:0] r4_sa [3];
    logic signed [51:0] n4_sv [3];
    logic signed [37:0] n4_sa [3];

    // Stage 5: rounded position, derivatives and internal vectors.
    logic  r_ev;
    t_tail r_e;
    t_tail n_e;

    always_comb begin
        logic signed [51:0] vs;
        logic signed [37:0] as;
        for (int a = 0; a < 3; a++) begin
            vs       = r3_pv0[a] + r3_pv1[a] + r3_pv2[a];
            as       = r3_pa0[a] + r3_pa1[a];
            n4_sv[a] = vs + (vs <<< 1);
            n4_sa[a] = (as <<< 1) + (as <<< 2);
        end
    end

    always_comb begin
        logic        [65:0] tot;
        logic signed [52:0] tv;
        logic signed [38:0] ta;
        n_e = '0;
        for (int a = 0; a < 3; a++) begin
            tot = {2'b0, r4_pp[a][0]} + {2'b0, r4_pp[a][1]} + {1'b0, r4_pp[a][1], 1'b0}
                + {2'b0, r4_pp[a][2]} + {1'b0, r4_pp[a][2], 1'b0} + {2'b0, r4_pp[a][3]}
                + (66'd1 << 47);
            n_e.pos[16 * a +: 16] = tot[63:48] ^ SIGN16;
            tv = 53'(r4_sv[a]) + (53'sd1 <<< 33);
            tv = tv >>> 34;
            n_e.vel[16 * a +: 16] = sat16($signed(tv[23:0]));
            tv = 53'(r4_sv[a]) + (53'sd1 <<< 29);
            tv = tv >>> 30;
            n_e.vi[a] = tv[20:0];
            ta = 39'(r4_sa[a]) + (39'sd1 <<< 19);
            ta = ta >>> 20;
            n_e.acc[16 * a +: 16] = sat16($signed(ta[23:0]));
            ta = 39'(r4_sa[a]) + (39'sd1 <<< 13);
            ta = ta >>> 14;
            n_e.ai[a] = ta[22:0];
        end
    end

    // Valid bits of the head stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r_ev <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r_ev <= r4_v;
        end
    end

    // Head stage payload.
    always_ff @(posedge i_clk) begin
        r1_t  <= i_item.t;
        r1_u  <= i_item.u;
        r2_t  <= r1_t;
        r2_u  <= r1_u;
        r2_uu <= r1_u * r1_u;
        r2_ut <= r1_u * r1_t;
        r2_tt <= r1_t * r1_t;
        r3_w[0] <= r2_uu * r2_u;
        r3_w[1] <= r2_uu * r2_t;
        r3_w[2] <= r2_tt * r2_u;
        r3_w[3] <= r2_tt * r2_t;
        for (int a = 0; a < 3; a++) begin
            r3_pv0[a] <= $signed({1'b0, r2_uu}) * d0[a];
            r3_pv1[a] <= $signed({1'b0, r2_ut, 1'b0}) * d1[a];
            r3_pv2[a] <= $signed({1'b0, r2_tt}) * d2[a];
            r3_pa0[a] <= $signed({1'b0, r2_u}) * e0[a];
            r3_pa1[a] <= $signed({1'b0, r2_t}) * e1[a];
            for (int k = 0; k < 4; k++) begin
                r4_pp[a][k] <= r3_w[k] * pu[a][k];
            end
            r4_sv[a] <= n4_sv[a];
            r4_sa[a] <= n4_sa[a];
        end
        r_e <= n_e;
    end

    // Tail pipeline: products, two square roots, three tangent divisions and
    // the curvature division, one step per stage.
    t_tail              r_tl [NT];
    logic [NT-1:0]      r_tv;

    for (genvar j = 0; j < NT; j++) begin : g_tl
        localparam int VSH = (j >= 4 && j <= 24) ? 40 - 2 * (j - 4) : 0;
        localparam int CSH = (j >= 4 && j <= 32) ? 56 - 2 * (j - 4) : 0;
        localparam int TSH = (j >= 27 && j <= 42) ? 42 - j : 0;

        t_tail prv;
        t_tail nxt;
        logic  prv_v;

        if (j == 0) begin : g_first
            assign prv   = r_e;
            assign prv_v = r_ev;
        end else begin : g_next
            assign prv   = r_tl[j - 1];
            assign prv_v = r_tv[j - 1];
        end

        always_comb begin : p_step
            logic signed [41:0] sq42;
            logic signed [44:0] dif;
            logic signed [59:0] c60;
            logic        [21:0] sp22;
            logic        [37:0] dsh;
            logic        [62:0] r2;
            logic        [62:0] den63;
            logic        [47:0] num48;
            logic        [25:0] rq;
            logic        [15:0] tcomp;
            logic        [20:0] mag21;
            logic               bitv;
            nxt = prv;
            // Squares and cross products of the derivative vectors.
            if (j == 0) begin
                for (int a = 0; a < 3; a++) begin
                    sq42        = $signed(prv.vi[a]) * $signed(prv.vi[a]);
                    nxt.sq[a]   = sq42[40:0];
                    nxt.vneg[a] = prv.vi[a][20];
                    mag21       = prv.vi[a][20] ? (21'd0 - prv.vi[a]) : prv.vi[a];
                    nxt.vmag[a] = mag21[19:0];
                end
                nxt.xp[0] = $signed(prv.vi[1]) * $signed(prv.ai[2]);
                nxt.xp[1] = $signed(prv.vi[2]) * $signed(prv.ai[1]);
                nxt.xp[2] = $signed(prv.vi[2]) * $signed(prv.ai[0]);
                nxt.xp[3] = $signed(prv.vi[0]) * $signed(prv.ai[2]);
                nxt.xp[4] = $signed(prv.vi[0]) * $signed(prv.ai[1]);
                nxt.xp[5] = $signed(prv.vi[1]) * $signed(prv.ai[0]);
            end
            // Squared speed and the rounded cross product.
            if (j == 1) begin
                nxt.v2 = {1'b0, prv.sq[0]} + {1'b0, prv.sq[1]} + {1'b0, prv.sq[2]};
                for (int a = 0; a < 3; a++) begin
                    dif = 45'($signed(prv.xp[2 * a])) - 45'($signed(prv.xp[2 * a + 1]))
                        + (45'sd1 <<< 14);
                    dif = dif >>> 15;
                    nxt.c[a] = dif[29:0];
                end
            end
            if (j == 2) begin
                for (int a = 0; a < 3; a++) begin
                    c60        = $signed(prv.c[a]) * $signed(prv.c[a]);
                    nxt.cs[a]  = c60[57:0];
                end
            end
            if (j == 3) begin
                nxt.csq.x = prv.cs[0] + prv.cs[1] + prv.cs[2];
                nxt.csq.r = '0;
                nxt.vsq.x = {16'd0, prv.v2};
                nxt.vsq.r = '0;
            end
            if (j >= 4 && j <= 24) begin
                nxt.vsq = sqrt_step(prv.vsq, 58'd1 << VSH);
            end
            if (j >= 4 && j <= 32) begin
                nxt.csq = sqrt_step(prv.csq, 58'd1 << CSH);
            end
            // Rounded speed, then the speed output code.
            if (j == 25) begin
                nxt.s = prv.vsq.r[20:0] + {20'd0, (prv.vsq.x > prv.vsq.r)};
                sp22  = {1'b0, nxt.s} + 22'd8;
                nxt.speed = (sp22[21:20] != 2'd0) ? 16'hFFFF : sp22[19:4];
            end
            // Tangent dividends and the square of the speed.
            if (j == 26) begin
                for (int a = 0; a < 3; a++) begin
                    nxt.tr[a] = {3'd0, prv.vmag[a], 15'd0} + {17'd0, prv.s};
                    nxt.tq[a] = '0;
                end
                nxt.ss = prv.s * prv.s;
            end
            if (j == 27) begin
                den63   = prv.ss * prv.s;
                nxt.den = den63[61:0];
            end
            // Restoring division of the tangent, one quotient bit per stage.
            if (j >= 27 && j <= 42) begin
                dsh = {16'd0, prv.s, 1'b0} << TSH;
                for (int a = 0; a < 3; a++) begin
                    if (prv.tr[a] >= dsh) begin
                        nxt.tr[a]      = prv.tr[a] - dsh;
                        nxt.tq[a][TSH] = 1'b1;
                    end
                end
            end
            if (j == 33) begin
                nxt.cn = prv.csq.r[29:0] + {29'd0, (prv.csq.x > prv.csq.r)};
            end
            // Overflow test of the curvature quotient.
            if (j == 34) begin
                num48    = {prv.cn, 18'd0};
                nxt.covf = {14'd0, num48} >= prv.den;
                nxt.crem = {15'd0, num48};
                nxt.cquo = '0;
            end
            if (j >= 35 && j <= 59) begin
                r2   = {prv.crem[61:0], 1'b0};
                bitv = 1'b0;
                if (r2 >= {1'b0, prv.den}) begin
                    r2   = r2 - {1'b0, prv.den};
                    bitv = 1'b1;
                end
                nxt.crem = r2;
                nxt.cquo = {prv.cquo[23:0], bitv};
            end
            // Final rounding, signs and the irregular case.
            if (j == 60) begin
                nxt.regular = (prv.speed != 16'd0);
                for (int a = 0; a < 3; a++) begin
                    tcomp = prv.vneg[a] ? (16'd0 - prv.tq[a]) : prv.tq[a];
                    nxt.tan[16 * a +: 16] = nxt.regular ? tcomp : 16'd0;
                end
                rq = {1'b0, prv.cquo} + 26'd1;
                rq = rq >> 1;
                if (!nxt.regular) begin
                    nxt.curv = '0;
                end else if (prv.covf || (rq[24:0] > {1'b0, CURV_MAX})) begin
                    nxt.curv = CURV_MAX;
                end else begin
                    nxt.curv = rq[23:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tv[j] <= 1'b0;
            end else begin
                r_tv[j] <= prv_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tl[j] <= nxt;
        end
    end

    // Result ports straight from the last stage.
    assign o_valid        = r_tv[NT - 1];
    assign o_position     = r_tl[NT - 1].pos;
    assign o_velocity     = r_tl[NT - 1].vel;
    assign o_acceleration = r_tl[NT - 1].acc;
    assign o_speed        = r_tl[NT - 1].speed;
    assign o_regular      = r_tl[NT - 1].regular;
    assign o_unit_tangent = r_tl[NT - 1].tan;
    assign o_curvature    = r_tl[NT - 1].curv;

endmodule

### hw/rtl/cubic_bezier_sample.sv
// Top level of the cubic Bezier sampler: control point registers and the pipeline.
//
// Usage: write the four control points P0..P3 through the configuration channel
// (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data), x y z packed as signed
// Q2.13, while no item is in flight. The channel is always ready.
// An item is the parameter t on i_fraction (unsigned Q1.16), taken at a rising
// edge with start high and busy low; values above one are treated as one.
// One result item follows each input item, in order: position, velocity,
// acceleration, speed, regular flag, unit tangent and curvature, shown for one
// cycle with o_valid high. The receiver cannot stall the block.
// Most of the pipeline depth comes from the two digit-by-digit square roots and the
// 25-bit curvature division, each of which takes one stage per step. Throughput is one
// item per cycle; busy stays low in steady use, since the pipeline drains its input
// queue every cycle. Reset clears the control points to zero and empties the pipeline.
module cubic_bezier_sample
    import bzs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [16:0] i_fraction,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output logic        o_valid,
    output logic [47:0] o_position,
    output logic [47:0] o_velocity,
    output logic [47:0] o_acceleration,
    output logic [15:0] o_speed,
    output logic        o_regular,
    output logic [47:0] o_unit_tangent,
    output logic [23:0] o_curvature
);

    t_points r_pt;
    logic    push;
    t_item   f_item;
    logic    q_full;
    logic    q_valid;
    t_item   q_item;

    assign o_cfg_ready = 1'b1;

    // Control point register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_P0:  r_pt[0] <= i_cfg_data;
                REG_P1:  r_pt[1] <= i_cfg_data;
                REG_P2:  r_pt[2] <= i_cfg_data;
                REG_P3:  r_pt[3] <= i_cfg_data;
                default: r_pt    <= r_pt;
            endcase
        end
    end

    // Front end, queue and evaluation pipeline.
    bzs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_fraction (i_fraction),
        .i_full     (q_full),
        .o_push     (push),
        .o_item     (f_item)
    );

    bzs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    bzs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .i_points       (r_pt),
        .o_valid        (o_valid),
        .o_position     (o_position),
        .o_velocity     (o_velocity),
        .o_acceleration (o_acceleration),
        .o_speed        (o_speed),
        .o_regular      (o_regular),
        .o_unit_tangent (o_unit_tangent),
        .o_curvature    (o_curvature)
    );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the cubic Bezier sampler, with its own fixed-point predictor.
module tb_top;
    import bzs_pkg::*;

    // One predicted or observed sample of the curve.
    typedef struct {
        logic [47:0] pos;
        logic [47:0] vel;
        logic [47:0] acc;
        logic [15:0] speed;
        logic        regular;
        logic [47:0] tan;
        logic [23:0] curv;
    } t_sample;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [16:0] i_fraction;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [47:0] i_cfg_data;
    logic        o_valid;
    logic [47:0] o_position;
    logic [47:0] o_velocity;
    logic [47:0] o_acceleration;
    logic [15:0] o_speed;
    logic        o_regular;
    logic [47:0] o_unit_tangent;
    logic [23:0] o_curvature;

    // Control points as the predictor sees them.
    logic [47:0] ctrl_pts [4];
    t_sample     samples_due [$];
    int          mismatches;
    int          items_sent;
    int          samples_seen;
    int          irregular_seen;
    int          curv_sat_seen;

    cubic_bezier_sample dut (.*);

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit.
    initial begin
        #30000000;
        $display("simulation failed");
        $finish;
    end

    // Round half up on a right shift.
    function automatic longint signed round_shr(longint signed v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // Clamp to 16-bit two's complement.
    function automatic logic [15:0] clamp16(longint signed v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // Integer square root rounded to nearest.
    function automatic longint unsigned root_round(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (x > r) r++;
        return r;
    endfunction

    // Curvature quotient num * 2^42 / den, rounded, saturating.
    function automatic logic [23:0] curvature_quot(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = num / den;
        r = num % den;
        if (q >= (64'd1 << 25)) return CURV_MAX;
        for (int i = 0; i < 43; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
            if (q >= (64'd1 << 25)) return CURV_MAX;
        end
        q = (q + 1) >> 1;
        if (q > CURV_MAX) return CURV_MAX;
        return q[23:0];
    endfunction

    // Evaluate the curve at one parameter value.
    function automatic t_sample predict_sample(logic [16:0] frac);
        t_sample         res;
        longint unsigned t;
        longint unsigned u;
        longint unsigned pu [4];
        longint signed   p [4];
        longint unsigned sum;
        longint signed   d0, d1, d2, e0, e1, sv, sa, n, q;
        longint signed   vi [3];
        longint signed   ai [3];
        longint signed   c [3];
        longint unsigned v2, s, sp, mag, c2, cn;
        logic [15:0]     raw;
        t = frac;
        if (t > ONE_T) t = ONE_T;
        u = 65536 - t;
        v2 = 0;
        res.pos = '0;
        res.vel = '0;
        res.acc = '0;
        res.tan = '0;
        res.curv = '0;
        for (int ax = 0; ax < 3; ax++) begin
            for (int k = 0; k < 4; k++) begin
                raw = ctrl_pts[k][16*ax +: 16];
                pu[k] = raw ^ SIGN16;
                p[k] = longint'($signed(raw));
            end
            sum = u * u * u * pu[0] + 3 * u * u * t * pu[1]
                + 3 * u * t * t * pu[2] + t * t * t * pu[3];
            sum = (sum + (64'd1 << 47)) >> 48;
            res.pos[16*ax +: 16] = sum[15:0] ^ SIGN16;
            d0 = p[1] - p[0];
            d1 = p[2] - p[1];
            d2 = p[3] - p[2];
            sv = 3 * (longint'(u * u) * d0 + longint'(2 * u * t) * d1 + longint'(t * t) * d2);
            e0 = p[2] - 2 * p[1] + p[0];
            e1 = p[3] - 2 * p[2] + p[1];
            sa = 6 * (longint'(u) * e0 + longint'(t) * e1);
            res.vel[16*ax +: 16] = clamp16(round_shr(sv, 34));
            res.acc[16*ax +: 16] = clamp16(round_shr(sa, 20));
            vi[ax] = round_shr(sv, 30);
            ai[ax] = round_shr(sa, 14);
            v2 += longint'(vi[ax] * vi[ax]);
        end
        s = root_round(v2);
        sp = (s + 8) >> 4;
        if (sp > 65535) sp = 65535;
        res.speed = sp[15:0];
        res.regular = (sp != 0);
        if (sp != 0) begin
            for (int ax = 0; ax < 3; ax++) begin
                n = vi[ax] * 16384;
                mag = (n < 0) ? longint'(-n) : longint'(n);
                q = longint'((2 * mag + s) / (2 * s));
                res.tan[16*ax +: 16] = clamp16((n < 0) ? -q : q);
            end
            c[0] = round_shr(vi[1] * ai[2] - vi[2] * ai[1], 15);
            c[1] = round_shr(vi[2] * ai[0] - vi[0] * ai[2], 15);
            c[2] = round_shr(vi[0] * ai[1] - vi[1] * ai[0], 15);
            c2 = 0;
            for (int ax = 0; ax < 3; ax++) c2 += longint'(c[ax] * c[ax]);
            cn = root_round(c2);
            res.curv = curvature_quot(cn, s * s * s);
        end
        return res;
    endfunction

    // Compare every result with the oldest prediction.
    always @(posedge i_clk) begin
        t_sample exp_s;
        if (i_rst_n && o_valid) begin
            samples_seen++;
            if (samples_due.size() == 0) begin
                $display("%0t: unexpected result, position %h", $time, o_position);
                mismatches++;
            end else begin
                exp_s = samples_due.pop_front();
                if (!o_regular) irregular_seen++;
                if (o_curvature == CURV_MAX) curv_sat_seen++;
                if (o_position !== exp_s.pos) begin
                    $display("%0t: position exp %h got %h", $time, exp_s.pos, o_position);
                    mismatches++;
                end
                if (o_velocity !== exp_s.vel) begin
                    $display("%0t: velocity exp %h got %h", $time, exp_s.vel, o_velocity);
                    mismatches++;
                end
                if (o_acceleration !== exp_s.acc) begin
                    $display("%0t: acceleration exp %h got %h", $time, exp_s.acc,
                             o_acceleration);
                    mismatches++;
                end
                if (o_speed !== exp_s.speed) begin
                    $display("%0t: speed exp %h got %h", $time, exp_s.speed, o_speed);
                    mismatches++;
                end
                if (o_regular !== exp_s.regular) begin
                    $display("%0t: regular exp %b got %b", $time, exp_s.regular, o_regular);
                    mismatches++;
                end
                if (o_unit_tangent !== exp_s.tan) begin
                    $display("%0t: tangent exp %h got %h", $time, exp_s.tan, o_unit_tangent);
                    mismatches++;
                end
                if (o_curvature !== exp_s.curv) begin
                    $display("%0t: curvature exp %h got %h", $time, exp_s.curv, o_curvature);
                    mismatches++;
                end
            end
        end
    end

    // Send one item; start stays high so a burst can follow directly.
    task automatic send_item(logic [16:0] frac);
        start <= 1'b1;
        i_fraction <= frac;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        samples_due.push_back(predict_sample(frac));
        items_sent++;
    endtask

    // Wait until all results are back and the pipeline is empty.
    task automatic drain();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (samples_due.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    // Write one control point register while the block is idle; valid stays high.
    task automatic write_point(logic [1:0] idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        ctrl_pts[idx] = data;
    endtask

    task automatic load_points(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                               logic [47:0] d);
        drain();
        write_point(REG_P0, a);
        write_point(REG_P1, b);
        write_point(REG_P2, c);
        write_point(REG_P3, d);
        i_cfg_valid <= 1'b0;
    endtask

    // Parameter value: mostly in range, sometimes above one.
    function automatic logic [16:0] rand_fraction();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 17'($urandom_range(65537, 131071));
        if (sel == 1) return ONE_T;
        if (sel == 2) return 17'd0;
        return 17'($urandom_range(0, 65536));
    endfunction

    // Random control point with a chosen spread around a base.
    function automatic logic [47:0] near_point(logic [47:0] base, int spread);
        logic [47:0] r;
        for (int ax = 0; ax < 3; ax++)
            r[16*ax +: 16] = base[16*ax +: 16] + 16'($urandom_range(0, 2 * spread) - spread);
        return r;
    endfunction

    // Stream a number of random items in bursts with random gaps.
    task automatic stream_items(int count);
        int burst;
        int gap;
        while (count > 0) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && count > 0; i++) begin
                send_item(rand_fraction());
                count--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Zero control points after reset: the curve is not regular anywhere.
    task automatic test_reset_points();
        send_item(17'd0);
        send_item(17'd32768);
        send_item(ONE_T);
        drain();
    endtask

    // Extreme control points and parameter values.
    task automatic test_extremes();
        load_points(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
                    48'h8000_8000_8000);
        send_item(17'd0);
        send_item(17'd1);
        send_item(17'd32768);
        send_item(17'd65535);
        send_item(ONE_T);
        send_item(17'h1FFFF);
        load_points(48'h8000_7FFF_0000, 48'h7FFF_8000_FFFF, 48'h0001_FFFF_8000,
                    48'hFFFF_0000_7FFF);
        send_item(17'd16384);
        send_item(17'd49152);
        send_item(17'd65537);
        // Coincident points give zero speed.
        load_points(48'h1234_5678_9ABC, 48'h1234_5678_9ABC, 48'h1234_5678_9ABC,
                    48'h1234_5678_9ABC);
        send_item(17'd100);
        send_item(17'd40000);
        // Collinear points give zero curvature.
        load_points(48'h0000_0000_0000, 48'h0100_0100_0100, 48'h0200_0200_0200,
                    48'h0300_0300_0300);
        send_item(17'd20000);
        // A curve that bends in the x-y plane, sampled around its midpoint.
        load_points(48'h0000_0000_0000, 48'h0000_0000_2000, 48'h0000_2000_0000,
                    48'h0000_0000_0000);
        send_item(17'd32768);
        send_item(17'd32769);
        send_item(17'd32700);
        drain();
    endtask

    // Random configurations with random streams; ends with a full drain each time.
    task automatic test_random_curves(int phases, int per_phase);
        logic [47:0] base;
        int          spread;
        for (int ph = 0; ph < phases; ph++) begin
            base = 48'({$urandom(), $urandom()});
            case ($urandom_range(0, 3))
                0: spread = 32768;
                1: spread = 2000;
                2: spread = 40;
                default: spread = 2;
            endcase
            load_points(near_point(base, spread), near_point(base, spread),
                        near_point(base, spread), near_point(base, spread));
            stream_items(per_phase);
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_fraction = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        mismatches = 0;
        items_sent = 0;
        samples_seen = 0;
        irregular_seen = 0;
        curv_sat_seen = 0;
        for (int k = 0; k < 4; k++) ctrl_pts[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_points();
        test_extremes();
        test_random_curves(21, 50);

        if (samples_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, samples_due.size());
            mismatches++;
        end
        $display("Sent %0d parameter values over many control point sets; %0d results checked,",
                 items_sent, samples_seen);
        $display("%0d of them not regular and %0d with saturated curvature.",
                 irregular_seen, curv_sat_seen);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
